[rtl/core/smc_pkg.sv]
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types, codes and helpers of the multicore 16-bit processor step block.
// ----------------------------------------------------------------------------
package smc_pkg;

	// Defaults of the top-level parameters.
	localparam int ADDR_BITS_DEF = 16;
	localparam int MAX_CORES_DEF = 4;

	// Every core has sixteen registers; the last three have fixed roles.
	localparam int REG_COUNT = 16;
	localparam logic [3:0] R_PC = 4'd15;
	localparam logic [3:0] R_SP = 4'd14;
	localparam logic [3:0] R_FP = 4'd13;

	// Operation codes of an input item.
	localparam logic [1:0] OP_STEP    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_RESTART = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ACTIVE = 2'd0;
	localparam logic [1:0] CFG_RVEC   = 2'd1;
	localparam logic [1:0] CFG_IVEC   = 2'd2;

	// Instruction opcodes.
	localparam logic [7:0] OPC_LDM   = 8'h01;
	localparam logic [7:0] OPC_STM   = 8'h02;
	localparam logic [7:0] OPC_MOV   = 8'h03;
	localparam logic [7:0] OPC_LDI   = 8'h04;
	localparam logic [7:0] OPC_ADD   = 8'h05;
	localparam logic [7:0] OPC_SUB   = 8'h06;
	localparam logic [7:0] OPC_AND   = 8'h07;
	localparam logic [7:0] OPC_OR    = 8'h08;
	localparam logic [7:0] OPC_XOR   = 8'h09;
	localparam logic [7:0] OPC_SHL   = 8'h0a;
	localparam logic [7:0] OPC_SHR   = 8'h0b;
	localparam logic [7:0] OPC_INC   = 8'h0c;
	localparam logic [7:0] OPC_DEC   = 8'h0d;
	localparam logic [7:0] OPC_CMP   = 8'h0e;
	localparam logic [7:0] OPC_HALT  = 8'h0f;
	localparam logic [7:0] OPC_LDSP  = 8'h10;
	localparam logic [7:0] OPC_PUSH  = 8'h11;
	localparam logic [7:0] OPC_POP   = 8'h12;
	localparam logic [7:0] OPC_CALL  = 8'h13;
	localparam logic [7:0] OPC_RET   = 8'h14;
	localparam logic [7:0] OPC_INT   = 8'h15;
	localparam logic [7:0] OPC_LDR   = 8'h16;
	localparam logic [7:0] OPC_CALLR = 8'h17;
	localparam logic [7:0] OPC_STR   = 8'h18;
	localparam logic [7:0] OPC_JMP   = 8'h19;
	localparam logic [7:0] OPC_JZ    = 8'h1a;
	localparam logic [7:0] OPC_JC    = 8'h1b;
	localparam logic [7:0] OPC_NOT0  = 8'h1c;
	localparam logic [7:0] OPC_ID    = 8'h1d;
	localparam logic [7:0] OPC_SLEEP = 8'h1e;
	localparam logic [7:0] OPC_JE    = 8'h1f;
	localparam logic [7:0] OPC_JL    = 8'h20;
	localparam logic [7:0] OPC_JG    = 8'h21;

	// Status word bits.
	localparam logic [4:0] FLG_ZERO  = 5'd1;
	localparam logic [4:0] FLG_CARRY = 5'd2;
	localparam logic [4:0] FLG_EQUAL = 5'd4;
	localparam logic [4:0] FLG_LESS  = 5'd8;
	localparam logic [4:0] FLG_GREAT = 5'd16;

	// Micro-operations that the controller issues to the datapath.
	typedef enum logic [4:0] {
		UOP_NONE,
		UOP_ACCEPT,
		UOP_LOADCTX,
		UOP_WRMEM,
		UOP_RDMEM,
		UOP_RD_RVEC,
		UOP_RESTART,
		UOP_ADVANCE,
		UOP_FETCH,
		UOP_DECODE,
		UOP_RDA,
		UOP_RDB,
		UOP_EXEC,
		UOP_RD_T,
		UOP_RD_B,
		UOP_POP,
		UOP_LOAD_R1,
		UOP_PUSH_RET,
		UOP_CALL,
		UOP_RET1,
		UOP_RET2,
		UOP_RET3,
		UOP_RD_IVEC,
		UOP_SET_PC,
		UOP_COMMIT,
		UOP_RESULT
	} uop_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_RESTART,
		S_FETCH,
		S_DECODE,
		S_RDA,
		S_RDB,
		S_EXEC,
		S_X1,
		S_X2,
		S_COMMIT,
		S_DONE
	} state_t;

	typedef struct packed {
		uop_t uop;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] opc;
		logic       halted;
		logic       asleep;
		logic       out_free;
	} stat_t;

	// Register value as the instruction sees it: the three pointer registers
	// live in working copies, the others come from the register file read.
	function automatic logic [15:0] reg_val(input logic [3:0] r, input logic [15:0] pc,
			input logic [15:0] sp, input logic [15:0] fp, input logic [15:0] gen);
		logic [15:0] v;
		if (r == R_PC) begin
			v = pc;
		end else if (r == R_SP) begin
			v = sp;
		end else if (r == R_FP) begin
			v = fp;
		end else begin
			v = gen;
		end
		return v;
	endfunction

endpackage

[rtl/core/sixteen_bit_multicore_cpu_step.sv]
// ----------------------------------------------------------------------------
// sixteen_bit_multicore_cpu_step
// Several round-robin 16-bit cores sharing one word memory, one operation per
// beat. Each input beat is a step of the next core, a memory write, a memory
// read or a restart of all cores; each produces exactly one result beat. The
// block handles one operation at a time. A step visits the single read port
// of the shared memory and of the register file in turn for the fetch, the
// operand word and the two register operands; loads, pops and calls add the
// state S_X1, and return and interrupt add S_X1 and S_X2. A restart reads
// the word at the reset vector before it sets every PC. A finished result
// waits in an output register, so the next beat is taken while it is still
// stalled. Configuration is written through a plain write port; the user
// must write it only while the block is idle, and the block itself does not
// enforce it. Memory contents are undefined until written; all core state is
// cleared by reset, with every PC at zero rather than at the reset vector.
// ----------------------------------------------------------------------------
module sixteen_bit_multicore_cpu_step #(
	parameter int ADDR_BITS = smc_pkg::ADDR_BITS_DEF,
	parameter int MAX_CORES = smc_pkg::MAX_CORES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] mem_addr,
	input  logic [15:0] mem_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  core_index,
	output logic [15:0] pc_after,
	output logic [4:0]  flags,
	output logic        core_asleep,
	output logic        halted,
	output logic [15:0] read_word
);

	import smc_pkg::*;

	// The sequencer issues one micro-operation per cycle; the datapath
	// reports the pending operation, the decoded opcode and its own status.
	cmd_t  cmd;
	stat_t stat;

	smc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the core contexts, the register file, the shared
	// memory and the result register.
	smc_dp #(
		.ADDR_BITS (ADDR_BITS),
		.MAX_CORES (MAX_CORES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.op          (op),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.core_index  (core_index),
		.pc_after    (pc_after),
		.flags       (flags),
		.core_asleep (core_asleep),
		.halted      (halted),
		.read_word   (read_word)
	);

endmodule

[rtl/core/smc_ram.sv]
// ----------------------------------------------------------------------------
// smc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module smc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/smc_ctrl.sv]
// ----------------------------------------------------------------------------
// smc_ctrl
// Sequencer: walks each operation through its micro-operations.
// ----------------------------------------------------------------------------
module smc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  smc_pkg::stat_t stat,
	output smc_pkg::cmd_t  cmd
);

	import smc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.uop = UOP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.uop = UOP_ACCEPT;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.op)
					OP_STEP: begin
						if (stat.halted) begin
							state_d = S_DONE;
						end else if (stat.asleep) begin
							cmd.uop = UOP_ADVANCE;
							state_d = S_DONE;
						end else begin
							cmd.uop = UOP_LOADCTX;
							state_d = S_FETCH;
						end
					end
					OP_WRITE: begin
						cmd.uop = UOP_WRMEM;
						state_d = S_DONE;
					end
					OP_READ: begin
						cmd.uop = UOP_RDMEM;
						state_d = S_DONE;
					end
					default: begin
						cmd.uop = UOP_RD_RVEC;
						state_d = S_RESTART;
					end
				endcase
			end
			S_RESTART: begin
				cmd.uop = UOP_RESTART;
				state_d = S_DONE;
			end
			S_FETCH: begin
				cmd.uop = UOP_FETCH;
				state_d = S_DECODE;
			end
			S_DECODE: begin
				cmd.uop = UOP_DECODE;
				state_d = S_RDA;
			end
			S_RDA: begin
				cmd.uop = UOP_RDA;
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.uop = UOP_RDB;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_X1;
				case (stat.opc)
					OPC_LDM:                       cmd.uop = UOP_RD_T;
					OPC_LDR:                       cmd.uop = UOP_RD_B;
					OPC_POP:                       cmd.uop = UOP_POP;
					OPC_CALL, OPC_CALLR, OPC_INT:  cmd.uop = UOP_PUSH_RET;
					OPC_RET:                       cmd.uop = UOP_RET1;
					default: begin
						cmd.uop = UOP_EXEC;
						state_d = S_COMMIT;
					end
				endcase
			end
			S_X1: begin
				state_d = S_COMMIT;
				case (stat.opc)
					OPC_CALL, OPC_CALLR: cmd.uop = UOP_CALL;
					OPC_RET: begin
						cmd.uop = UOP_RET2;
						state_d = S_X2;
					end
					OPC_INT: begin
						cmd.uop = UOP_RD_IVEC;
						state_d = S_X2;
					end
					default:             cmd.uop = UOP_LOAD_R1;
				endcase
			end
			S_X2: begin
				state_d = S_COMMIT;
				if (stat.opc == OPC_RET) begin
					cmd.uop = UOP_RET3;
				end else begin
					cmd.uop = UOP_SET_PC;
				end
			end
			S_COMMIT: begin
				cmd.uop = UOP_COMMIT;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.uop = UOP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

`ifndef SYNTH
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item taken right after an accept");
`endif

endmodule

[rtl/core/smc_dp.sv]
// ----------------------------------------------------------------------------
// smc_dp
// Datapath: core contexts, register file, shared memory and result register.
// ----------------------------------------------------------------------------
module smc_dp #(
	parameter int ADDR_BITS = smc_pkg::ADDR_BITS_DEF,
	parameter int MAX_CORES = smc_pkg::MAX_CORES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  smc_pkg::cmd_t  cmd,
	output smc_pkg::stat_t stat,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_idx,
	input  logic [15:0]    cfg_wdata,
	input  logic [1:0]     op,
	input  logic [15:0]    mem_addr,
	input  logic [15:0]    mem_wdata,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     core_index,
	output logic [15:0]    pc_after,
	output logic [4:0]     flags,
	output logic           core_asleep,
	output logic           halted,
	output logic [15:0]    read_word
);

	import smc_pkg::*;

	localparam int CW       = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
	localparam int RF_AW    = CW + 4;
	localparam int RF_DEPTH = 1 << RF_AW;
	localparam int MEM_DEPTH = 1 << ADDR_BITS;

	// Configuration.
	logic [2:0]  act_q;
	logic [15:0] rvec_q;
	logic [15:0] ivec_q;

	// Per-core architectural state.
	logic [15:0] pc_arr_q  [MAX_CORES];
	logic [15:0] sp_arr_q  [MAX_CORES];
	logic [15:0] fp_arr_q  [MAX_CORES];
	logic [4:0]  flg_arr_q [MAX_CORES];
	logic        slp_arr_q [MAX_CORES];
	logic        rf_vld_q  [RF_DEPTH];
	logic [CW-1:0] next_q;
	logic        halted_q;

	// Item and working registers.
	logic [1:0]  op_q;
	logic [15:0] maddr_q;
	logic [15:0] mwdata_q;
	logic [CW-1:0] cur_q;
	logic [15:0] pc_q, sp_q, fp_q;
	logic [4:0]  flg_q;
	logic [15:0] inst_q, t_q, ag_q, bg_q;
	logic        dst_en_q;
	logic [3:0]  dst_idx_q;
	logic [15:0] dst_val_q;
	logic        rf_rvld_q;

	// Result register.
	logic        out_vld_q;
	logic [1:0]  out_core_q;
	logic [15:0] out_pc_q;
	logic [4:0]  out_flg_q;
	logic        out_slp_q;
	logic        out_halt_q;
	logic [15:0] out_rd_q;

	// Memory and register file ports.
	logic        mem_we, mem_re;
	logic [15:0] mem_wa, mem_ra, mem_wd, mem_rdata;
	logic        rf_we, rf_re;
	logic [RF_AW-1:0] rf_wa, rf_ra;
	logic [15:0] rf_rdata;
	logic [3:0]  rf_ridx;

	// Next working values.
	logic [15:0] n_pc, n_sp, n_fp;
	logic [4:0]  n_flg;
	logic        n_dst_en;
	logic [3:0]  n_dst_idx;
	logic [15:0] n_dst_val;
	logic        set_halt, set_sleep;

	logic [CW:0]   cnt;
	logic [CW-1:0] sel_c, adv_c;
	logic [7:0]  opc;
	logic [3:0]  r1, r2;
	logic [15:0] av, bv, ag, bg;

	smc_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa[ADDR_BITS-1:0]),
		.wdata (mem_wd),
		.re    (mem_re),
		.raddr (mem_ra[ADDR_BITS-1:0]),
		.rdata (mem_rdata)
	);

	smc_ram #(.WIDTH(16), .DEPTH(RF_DEPTH)) u_rf (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_wa),
		.wdata (dst_val_q),
		.re    (rf_re),
		.raddr (rf_ra),
		.rdata (rf_rdata)
	);

	// Round robin over the clamped core count.
	always_comb begin
		if (act_q == 3'd0) begin
			cnt = (CW+1)'(1);
		end else if (int'(act_q) > MAX_CORES) begin
			cnt = (CW+1)'(MAX_CORES);
		end else begin
			cnt = (CW+1)'(act_q);
		end
		sel_c = ({1'b0, next_q} >= cnt) ? '0 : next_q;
		adv_c = ({1'b0, cur_q} + (CW+1)'(1) == cnt) ? '0 : cur_q + CW'(1);
	end

	assign opc = inst_q[7:0];
	assign r1  = inst_q[11:8];
	assign r2  = inst_q[15:12];
	assign ag  = rf_rvld_q ? rf_rdata : 16'd0;
	assign bg  = bg_q;
	assign av  = reg_val(r1, pc_q, sp_q, fp_q, ag_q);
	assign bv  = reg_val(r2, pc_q, sp_q, fp_q, bg);

	always_comb begin
		logic        do_wr;
		logic [3:0]  wr_r;
		logic [15:0] wr_v;
		logic        inc_after;
		logic [15:0] res;
		logic [15:0] diff;
		logic [15:0] s2;
		logic [4:0]  mask;
		n_pc      = pc_q;
		n_sp      = sp_q;
		n_fp      = fp_q;
		n_flg     = flg_q;
		n_dst_en  = dst_en_q;
		n_dst_idx = dst_idx_q;
		n_dst_val = dst_val_q;
		set_halt  = 1'b0;
		set_sleep = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = 16'd0;
		mem_wd    = 16'd0;
		mem_re    = 1'b0;
		mem_ra    = 16'd0;
		rf_re     = 1'b0;
		rf_ridx   = 4'd0;
		do_wr     = 1'b0;
		wr_r      = r1;
		wr_v      = 16'd0;
		inc_after = 1'b0;
		res       = 16'd1;
		diff      = av - bv;
		s2        = sp_q - 16'd1;
		mask      = 5'd0;
		unique case (cmd.uop)
			UOP_WRMEM: begin
				mem_we = 1'b1;
				mem_wa = maddr_q;
				mem_wd = mwdata_q;
			end
			UOP_RDMEM: begin
				mem_re = 1'b1;
				mem_ra = maddr_q;
			end
			UOP_RD_RVEC: begin
				mem_re = 1'b1;
				mem_ra = rvec_q;
			end
			UOP_FETCH: begin
				mem_re = 1'b1;
				mem_ra = pc_q;
				n_pc   = pc_q + 16'd1;
			end
			UOP_DECODE: begin
				mem_re  = 1'b1;
				mem_ra  = pc_q;
				rf_re   = 1'b1;
				rf_ridx = mem_rdata[11:8];
			end
			UOP_RDA: begin
				rf_re   = 1'b1;
				rf_ridx = r2;
			end
			UOP_EXEC: begin
				case (opc)
					OPC_STM: begin
						mem_we = 1'b1;
						mem_wa = t_q;
						mem_wd = av;
						n_pc   = pc_q + 16'd1;
					end
					OPC_MOV: begin
						do_wr = 1'b1;
						wr_r  = r2;
						wr_v  = av;
					end
					OPC_LDI: begin
						do_wr     = 1'b1;
						wr_v      = t_q;
						inc_after = 1'b1;
					end
					OPC_ADD, OPC_SUB, OPC_AND, OPC_OR, OPC_XOR, OPC_SHL, OPC_SHR,
					OPC_INC, OPC_DEC: begin
						case (opc)
							OPC_ADD: res = av + bv;
							OPC_SUB: res = av - bv;
							OPC_AND: res = av & bv;
							OPC_OR:  res = av | bv;
							OPC_XOR: res = av ^ bv;
							OPC_SHL: res = (bv[15:4] != 12'd0) ? 16'd0 : (av << bv[3:0]);
							OPC_SHR: res = (bv[15:4] != 12'd0) ? 16'd0 : (av >> bv[3:0]);
							OPC_INC: res = av + 16'd1;
							default: res = av - 16'd1;
						endcase
						do_wr = 1'b1;
						wr_v  = res;
						if (res == 16'd0) begin
							n_flg = FLG_ZERO;
						end
					end
					OPC_CMP: begin
						if (diff[15]) begin
							n_flg = flg_q | FLG_LESS;
						end else if (diff == 16'd0) begin
							n_flg = flg_q | FLG_EQUAL;
						end else begin
							n_flg = flg_q | FLG_GREAT;
						end
					end
					OPC_HALT:  set_halt = 1'b1;
					OPC_LDSP: begin
						n_sp = t_q;
						n_fp = t_q;
						n_pc = pc_q + 16'd1;
					end
					OPC_PUSH: begin
						mem_we = 1'b1;
						mem_wa = sp_q;
						mem_wd = av;
						n_sp   = sp_q - 16'd1;
					end
					OPC_STR: begin
						mem_we = 1'b1;
						mem_wa = bv;
						mem_wd = av;
					end
					OPC_JMP:   n_pc = t_q;
					OPC_JZ, OPC_JC, OPC_JE, OPC_JL, OPC_JG: begin
						case (opc)
							OPC_JZ:  mask = FLG_ZERO;
							OPC_JC:  mask = FLG_CARRY;
							OPC_JE:  mask = FLG_EQUAL;
							OPC_JL:  mask = FLG_LESS;
							default: mask = FLG_GREAT;
						endcase
						n_pc = ((flg_q & mask) != 5'd0) ? t_q : pc_q + 16'd1;
					end
					OPC_NOT0: begin
						do_wr = 1'b1;
						wr_v  = (av == 16'd0) ? 16'd1 : 16'd0;
					end
					OPC_ID: begin
						do_wr = 1'b1;
						wr_v  = 16'(cur_q);
					end
					OPC_SLEEP: set_sleep = 1'b1;
					default: begin
					end
				endcase
			end
			UOP_RD_T: begin
				mem_re = 1'b1;
				mem_ra = t_q;
			end
			UOP_RD_B: begin
				mem_re = 1'b1;
				mem_ra = bv;
			end
			UOP_POP: begin
				n_sp   = sp_q + 16'd1;
				mem_re = 1'b1;
				mem_ra = sp_q + 16'd1;
			end
			UOP_LOAD_R1: begin
				do_wr     = 1'b1;
				wr_v      = mem_rdata;
				inc_after = (opc == OPC_LDM);
			end
			UOP_PUSH_RET: begin
				mem_we = 1'b1;
				mem_wa = sp_q;
				mem_wd = (opc == OPC_CALL) ? pc_q + 16'd1 : pc_q;
				n_sp   = sp_q - 16'd1;
			end
			UOP_CALL: begin
				mem_we = 1'b1;
				mem_wa = sp_q;
				mem_wd = fp_q;
				n_sp   = s2;
				n_fp   = s2;
				n_pc   = (opc == OPC_CALL) ? t_q : reg_val(r1, pc_q, s2, s2, ag_q);
			end
			UOP_RET1: begin
				n_sp   = fp_q + 16'd2;
				mem_re = 1'b1;
				mem_ra = fp_q + 16'd2;
			end
			UOP_RET2: begin
				n_pc   = mem_rdata;
				mem_re = 1'b1;
				mem_ra = s2;
			end
			UOP_RET3:    n_fp = mem_rdata;
			UOP_RD_IVEC: begin
				mem_re = 1'b1;
				mem_ra = ivec_q;
			end
			UOP_SET_PC:  n_pc = mem_rdata;
			default: begin
			end
		endcase
		// Register write: the pointer registers go to their working copies.
		if (do_wr) begin
			if (wr_r == R_PC) begin
				n_pc = wr_v;
			end else if (wr_r == R_SP) begin
				n_sp = wr_v;
			end else if (wr_r == R_FP) begin
				n_fp = wr_v;
			end else begin
				n_dst_en  = 1'b1;
				n_dst_idx = wr_r;
				n_dst_val = wr_v;
			end
		end
		if (inc_after) begin
			n_pc = n_pc + 16'd1;
		end
	end

	assign rf_ra = {cur_q, rf_ridx};
	assign rf_we = (cmd.uop == UOP_COMMIT) && dst_en_q;
	assign rf_wa = {cur_q, dst_idx_q};

	// Control state: contexts, pointer, halt, configuration, valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 3'd1;
			rvec_q   <= 16'd0;
			ivec_q   <= 16'd1;
			next_q   <= '0;
			halted_q <= 1'b0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < MAX_CORES; i++) begin
				pc_arr_q[i]  <= 16'd0;
				sp_arr_q[i]  <= 16'd0;
				fp_arr_q[i]  <= 16'd0;
				flg_arr_q[i] <= 5'd0;
				slp_arr_q[i] <= 1'b0;
			end
			for (int i = 0; i < RF_DEPTH; i++) begin
				rf_vld_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_ACTIVE: act_q  <= cfg_wdata[2:0];
					CFG_RVEC:   rvec_q <= cfg_wdata;
					CFG_IVEC:   ivec_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			if (cmd.uop == UOP_RESULT) begin
				out_vld_q <= 1'b1;
			end
			if (cmd.uop == UOP_ACCEPT && op == OP_STEP) begin
				next_q <= sel_c;
			end
			if (cmd.uop == UOP_ADVANCE) begin
				next_q <= adv_c;
			end
			if (set_halt) begin
				halted_q <= 1'b1;
			end
			if (set_sleep) begin
				slp_arr_q[cur_q] <= 1'b1;
			end
			if (cmd.uop == UOP_COMMIT) begin
				pc_arr_q[cur_q]  <= pc_q;
				sp_arr_q[cur_q]  <= sp_q;
				fp_arr_q[cur_q]  <= fp_q;
				flg_arr_q[cur_q] <= flg_q;
				next_q           <= adv_c;
				if (dst_en_q) begin
					rf_vld_q[rf_wa] <= 1'b1;
				end
			end
			if (cmd.uop == UOP_RESTART) begin
				for (int i = 0; i < MAX_CORES; i++) begin
					pc_arr_q[i]  <= mem_rdata;
					slp_arr_q[i] <= 1'b0;
				end
				next_q   <= '0;
				halted_q <= 1'b0;
			end
		end
	end

	// Payload, working and result registers.
	always_ff @(posedge clk) begin
		if (cmd.uop == UOP_ACCEPT) begin
			op_q     <= op;
			maddr_q  <= mem_addr;
			mwdata_q <= mem_wdata;
			cur_q    <= sel_c;
		end
		if (cmd.uop == UOP_LOADCTX) begin
			pc_q     <= pc_arr_q[cur_q];
			sp_q     <= sp_arr_q[cur_q];
			fp_q     <= fp_arr_q[cur_q];
			flg_q    <= flg_arr_q[cur_q];
			dst_en_q <= 1'b0;
		end else begin
			pc_q      <= n_pc;
			sp_q      <= n_sp;
			fp_q      <= n_fp;
			flg_q     <= n_flg;
			dst_en_q  <= n_dst_en;
		end
		dst_idx_q <= n_dst_idx;
		dst_val_q <= n_dst_val;
		if (rf_re) begin
			rf_rvld_q <= rf_vld_q[rf_ra];
		end
		if (cmd.uop == UOP_DECODE) begin
			inst_q <= mem_rdata;
		end
		if (cmd.uop == UOP_RDA) begin
			t_q  <= mem_rdata;
			ag_q <= ag;
		end
		if (cmd.uop == UOP_RDB) begin
			bg_q <= ag;
		end
		if (cmd.uop == UOP_RESULT) begin
			out_halt_q <= halted_q;
			out_rd_q   <= (op_q == OP_READ) ? mem_rdata : 16'd0;
			if (op_q == OP_STEP) begin
				out_core_q <= 2'(cur_q);
				out_pc_q   <= pc_arr_q[cur_q];
				out_flg_q  <= flg_arr_q[cur_q];
				out_slp_q  <= slp_arr_q[cur_q];
			end else begin
				out_core_q <= 2'd0;
				out_pc_q   <= 16'd0;
				out_flg_q  <= 5'd0;
				out_slp_q  <= 1'b0;
			end
		end
	end

	assign stat.op       = op_q;
	assign stat.opc      = opc;
	assign stat.halted   = halted_q;
	assign stat.asleep   = slp_arr_q[cur_q];
	assign stat.out_free = !out_vld_q || !out_stall;

	assign out_valid   = out_vld_q;
	assign core_index  = out_core_q;
	assign pc_after    = out_pc_q;
	assign flags       = out_flg_q;
	assign core_asleep = out_slp_q;
	assign halted      = out_halt_q;
	assign read_word   = out_rd_q;

`ifndef SYNTH
	a_halt_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(halted_q) |-> $past(cmd.uop == UOP_EXEC && opc == OPC_HALT))
		else $error("halt set without a halt instruction");
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(cmd.uop == UOP_RESULT))
		else $error("result appeared without a result load");
	a_rf_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> (dst_idx_q != R_PC && dst_idx_q != R_SP && dst_idx_q != R_FP))
		else $error("pointer register written to the register file");
`endif

endmodule

[test/sixteen_bit_multicore_cpu_step_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sixteen_bit_multicore_cpu_step_tb
// Self-checking bench for the multicore 16-bit processor step block. All of
// memory is filled with instruction-like words first, so no program ever
// reads a word that was never written. A short directed sequence and phases
// of random steps, memory writes, reads and restarts follow, each phase under
// its own core count and vector addresses. A local machine model predicts
// every result beat, and the monitor checks the beats in order.
// ----------------------------------------------------------------------------
module sixteen_bit_multicore_cpu_step_tb;
	import smc_pkg::*;

	// The full memory fill dominates the run. The cap is several times the
	// slowest expected run.
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] addr;
		logic [15:0] wdata;
	} cpu_op_t;

	typedef struct {
		logic [1:0]  core_index;
		logic [15:0] pc_after;
		logic [4:0]  flags;
		logic        core_asleep;
		logic        halted;
		logic [15:0] read_word;
	} cpu_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op = '0;
	logic [15:0] mem_addr = '0;
	logic [15:0] mem_wdata = '0;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  core_index;
	logic [15:0] pc_after;
	logic [4:0]  flags;
	logic        core_asleep;
	logic        halted;
	logic [15:0] read_word;

	sixteen_bit_multicore_cpu_step dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .mem_addr(mem_addr), .mem_wdata(mem_wdata),
		.out_valid(out_valid), .out_stall(out_stall),
		.core_index(core_index), .pc_after(pc_after), .flags(flags),
		.core_asleep(core_asleep), .halted(halted), .read_word(read_word)
	);

	// Operations waiting for the driver, and the results that they will cause.
	cpu_op_t     pending_ops[$];
	cpu_result_t expected_results[$];
	int          mismatches = 0;

	// Local copy of the machine: memory, registers, status and the settings.
	logic [15:0] shadow_mem [0:65535];
	logic [15:0] shadow_regs [0:63];
	logic [4:0]  shadow_flags [0:3];
	logic        shadow_sleep [0:3];
	int          shadow_next;
	logic        shadow_halted;
	logic [2:0]  set_cores;
	logic [15:0] set_rvec;
	logic [15:0] set_ivec;

	// Pressure controls: the receiver holds off once on request.
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Executes one instruction on core c of the local machine. Register 15 is
	// the program counter, 14 the stack pointer and 13 the frame pointer; the
	// order of updates matters when an operand register is one of them.
	task automatic exec_instruction(input int c);
		int          b;
		int          r1;
		int          r2;
		logic [15:0] inst;
		logic [15:0] res;
		logic [15:0] d;
		logic [7:0]  opc;
		logic [4:0]  mask;
		b = c * 16;
		inst = shadow_mem[shadow_regs[b+15]];
		shadow_regs[b+15] = shadow_regs[b+15] + 16'd1;
		res = 16'd1;
		opc = inst[7:0];
		r1 = inst[11:8];
		r2 = inst[15:12];
		case (opc)
			OPC_LDM: begin
				shadow_regs[b+r1] = shadow_mem[shadow_mem[shadow_regs[b+15]]];
				shadow_regs[b+15] = shadow_regs[b+15] + 16'd1;
			end
			OPC_STM: begin
				shadow_mem[shadow_mem[shadow_regs[b+15]]] = shadow_regs[b+r1];
				shadow_regs[b+15] = shadow_regs[b+15] + 16'd1;
			end
			OPC_MOV: shadow_regs[b+r2] = shadow_regs[b+r1];
			OPC_LDI: begin
				shadow_regs[b+r1] = shadow_mem[shadow_regs[b+15]];
				shadow_regs[b+15] = shadow_regs[b+15] + 16'd1;
			end
			OPC_LDR: shadow_regs[b+r1] = shadow_mem[shadow_regs[b+r2]];
			OPC_STR: shadow_mem[shadow_regs[b+r2]] = shadow_regs[b+r1];
			OPC_ADD, OPC_SUB, OPC_AND, OPC_OR, OPC_XOR, OPC_SHL, OPC_SHR: begin
				case (opc)
					OPC_ADD: res = shadow_regs[b+r1] + shadow_regs[b+r2];
					OPC_SUB: res = shadow_regs[b+r1] - shadow_regs[b+r2];
					OPC_AND: res = shadow_regs[b+r1] & shadow_regs[b+r2];
					OPC_OR:  res = shadow_regs[b+r1] | shadow_regs[b+r2];
					OPC_XOR: res = shadow_regs[b+r1] ^ shadow_regs[b+r2];
					// A shift of sixteen or more clears the register.
					OPC_SHL: res = (shadow_regs[b+r2] >= 16) ? 16'd0 :
						shadow_regs[b+r1] << shadow_regs[b+r2][3:0];
					default: res = (shadow_regs[b+r2] >= 16) ? 16'd0 :
						shadow_regs[b+r1] >> shadow_regs[b+r2][3:0];
				endcase
				shadow_regs[b+r1] = res;
			end
			OPC_INC: begin
				shadow_regs[b+r1] = shadow_regs[b+r1] + 16'd1;
				res = shadow_regs[b+r1];
			end
			OPC_DEC: begin
				shadow_regs[b+r1] = shadow_regs[b+r1] - 16'd1;
				res = shadow_regs[b+r1];
			end
			OPC_CMP: begin
				d = shadow_regs[b+r1] - shadow_regs[b+r2];
				if (d[15]) begin
					shadow_flags[c] = shadow_flags[c] | FLG_LESS;
				end else if (d == 16'd0) begin
					shadow_flags[c] = shadow_flags[c] | FLG_EQUAL;
				end else begin
					shadow_flags[c] = shadow_flags[c] | FLG_GREAT;
				end
			end
			OPC_HALT: shadow_halted = 1'b1;
			OPC_LDSP: begin
				shadow_regs[b+14] = shadow_mem[shadow_regs[b+15]];
				shadow_regs[b+13] = shadow_regs[b+14];
				shadow_regs[b+15] = shadow_regs[b+15] + 16'd1;
			end
			OPC_PUSH: begin
				shadow_mem[shadow_regs[b+14]] = shadow_regs[b+r1];
				shadow_regs[b+14] = shadow_regs[b+14] - 16'd1;
			end
			OPC_POP: begin
				shadow_regs[b+14] = shadow_regs[b+14] + 16'd1;
				shadow_regs[b+r1] = shadow_mem[shadow_regs[b+14]];
			end
			OPC_CALL: begin
				shadow_mem[shadow_regs[b+14]] = shadow_regs[b+15] + 16'd1;
				shadow_regs[b+14] = shadow_regs[b+14] - 16'd1;
				shadow_mem[shadow_regs[b+14]] = shadow_regs[b+13];
				shadow_regs[b+14] = shadow_regs[b+14] - 16'd1;
				shadow_regs[b+13] = shadow_regs[b+14];
				shadow_regs[b+15] = shadow_mem[shadow_regs[b+15]];
			end
			OPC_RET: begin
				shadow_regs[b+14] = shadow_regs[b+13] + 16'd2;
				shadow_regs[b+15] = shadow_mem[shadow_regs[b+14]];
				shadow_regs[b+13] = shadow_mem[shadow_regs[b+14] - 16'd1];
			end
			OPC_INT: begin
				shadow_mem[shadow_regs[b+14]] = shadow_regs[b+15];
				shadow_regs[b+14] = shadow_regs[b+14] - 16'd1;
				shadow_regs[b+15] = shadow_mem[set_ivec];
			end
			OPC_CALLR: begin
				shadow_mem[shadow_regs[b+14]] = shadow_regs[b+15];
				shadow_regs[b+14] = shadow_regs[b+14] - 16'd1;
				shadow_mem[shadow_regs[b+14]] = shadow_regs[b+13];
				shadow_regs[b+14] = shadow_regs[b+14] - 16'd1;
				shadow_regs[b+13] = shadow_regs[b+14];
				shadow_regs[b+15] = shadow_regs[b+r1];
			end
			OPC_JMP: shadow_regs[b+15] = shadow_mem[shadow_regs[b+15]];
			OPC_JZ, OPC_JC, OPC_JE, OPC_JL, OPC_JG: begin
				case (opc)
					OPC_JZ:  mask = FLG_ZERO;
					OPC_JC:  mask = FLG_CARRY;
					OPC_JE:  mask = FLG_EQUAL;
					OPC_JL:  mask = FLG_LESS;
					default: mask = FLG_GREAT;
				endcase
				// An untaken jump skips its target word.
				if ((shadow_flags[c] & mask) != 5'd0) begin
					shadow_regs[b+15] = shadow_mem[shadow_regs[b+15]];
				end else begin
					shadow_regs[b+15] = shadow_regs[b+15] + 16'd1;
				end
			end
			OPC_NOT0: shadow_regs[b+r1] = (shadow_regs[b+r1] == 16'd0) ? 16'd1 : 16'd0;
			OPC_ID: shadow_regs[b+r1] = 16'(c);
			OPC_SLEEP: shadow_sleep[c] = 1'b1;
			default: ;
		endcase
		// An arithmetic result of zero replaces the status by the zero bit alone.
		if (opc > OPC_LDI && opc < OPC_HALT && res == 16'd0) begin
			shadow_flags[c] = FLG_ZERO;
		end
	endtask

	// Applies one operation to the local machine, queues it for the driver
	// and queues the result beat that it must produce.
	task automatic issue_op(input logic [1:0] o, input logic [15:0] a, input logic [15:0] w);
		cpu_op_t     item;
		cpu_result_t r;
		int          n;
		int          c;
		r = '{default: '0};
		if (o == OP_STEP) begin
			// A core count of zero acts as one, a count past four as four.
			n = (set_cores == 3'd0) ? 1 : (set_cores > 3'd4) ? 4 : int'(set_cores);
			if (shadow_next >= n) begin
				shadow_next = 0;
			end
			c = shadow_next;
			if (!shadow_halted) begin
				if (!shadow_sleep[c]) begin
					exec_instruction(c);
				end
				shadow_next = (c + 1) % n;
			end
			r.core_index = 2'(c);
			r.pc_after = shadow_regs[c*16+15];
			r.flags = shadow_flags[c];
			r.core_asleep = shadow_sleep[c];
		end else if (o == OP_WRITE) begin
			shadow_mem[a] = w;
		end else if (o == OP_READ) begin
			r.read_word = shadow_mem[a];
		end else begin
			for (int i = 0; i < 4; i++) begin
				shadow_regs[i*16+15] = shadow_mem[set_rvec];
				shadow_sleep[i] = 1'b0;
			end
			shadow_next = 0;
			shadow_halted = 1'b0;
		end
		r.halted = shadow_halted;
		item.op = o;
		item.addr = a;
		item.wdata = w;
		pending_ops.push_back(item);
		expected_results.push_back(r);
	endtask

	// Mostly valid opcodes with random register fields; halt and sleep are
	// kept rare so that programs run for a while between restarts.
	function automatic logic [15:0] random_instruction();
		logic [7:0] opc;
		if ($urandom_range(0, 9) == 0) begin
			return 16'($urandom);
		end
		opc = 8'($urandom_range(0, 8'h21));
		if ((opc == OPC_HALT || opc == OPC_SLEEP) && $urandom_range(0, 5) != 0) begin
			opc = OPC_INC;
		end
		return {8'($urandom), opc};
	endfunction

	// Waits until the driver is empty and every result has arrived, then lets
	// the block settle.
	task automatic wait_drained();
		while (pending_ops.size() != 0 || expected_results.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);
	endtask

	task automatic write_setting(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ACTIVE) begin
			set_cores = val[2:0];
		end else if (idx == CFG_RVEC) begin
			set_rvec = val;
		end else begin
			set_ivec = val;
		end
	endtask

	// Sender: bursts of random length separated by random gaps. A beat on
	// offer is held until the block takes it.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				cpu_op_t item;
				item = pending_ops.pop_front();
				op <= item.op;
				mem_addr <= item.addr;
				mem_wdata <= item.wdata;
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: the stall pattern moves through none, light, even and heavy
	// with bits 7:6 of its counter. Once asked, it holds off for a long stretch
	// so that the output register fills and the block stalls its input.
	bit [31:0] stall_cycle = 0;
	int        hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			stall_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_go && !hold_done) begin
				hold_done <= 1'b1;
				hold_left = 400;
				out_stall <= 1'b1;
			end else begin
				case (stall_cycle[7:6])
					2'd0: out_stall <= 1'b0;
					2'd1: out_stall <= ($urandom_range(0, 3) == 0);
					2'd2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	// Monitor: each accepted result beat is matched with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result beat: core %0d pc %h", core_index, pc_after);
				end
			end else begin
				cpu_result_t e;
				e = expected_results.pop_front();
				if (core_index !== e.core_index || pc_after !== e.pc_after ||
						flags !== e.flags || core_asleep !== e.core_asleep ||
						halted !== e.halted || read_word !== e.read_word) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected core %0d pc %h flags %h sleep %b halt %b rd %h",
							e.core_index, e.pc_after, e.flags, e.core_asleep, e.halted,
							e.read_word);
						$display("          actual   core %0d pc %h flags %h sleep %b halt %b rd %h",
							core_index, pc_after, flags, core_asleep, halted, read_word);
					end
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	int cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sixteen_bit_multicore_cpu_step test failed");
			$finish;
		end
	end

	// Stimulus. Settings per phase: core count, reset vector, interrupt vector.
	logic [2:0]  phase_cores [0:5] = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd1};
	logic [15:0] phase_rvec  [0:5] = '{16'hffff, 16'h0000, 16'h1234, 16'h8000, 16'h00ff, 16'hfffe};
	logic [15:0] phase_ivec  [0:5] = '{16'h0000, 16'hffff, 16'h0002, 16'h7fff, 16'hfff0, 16'h4321};

	initial begin
		int k;
		int sel;
		for (int i = 0; i < 64; i++) begin
			shadow_regs[i] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			shadow_flags[i] = '0;
			shadow_sleep[i] = 1'b0;
		end
		shadow_next = 0;
		shadow_halted = 1'b0;
		set_cores = 3'd1;
		set_rvec = 16'h0000;
		set_ivec = 16'h0001;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Fill every memory word so that no instruction, operand or stack
		// access can ever touch an unwritten word.
		for (int a = 0; a < 65536; a++) begin
			issue_op(OP_WRITE, 16'(a), random_instruction());
		end

		// Directed: memory extremes, then a short program at 0x100 under the
		// reset settings: a load of 16 and a shift by it, which must clear the
		// register, then halt, a step while halted, and a sleeping core.
		issue_op(OP_WRITE, 16'hffff, 16'hffff);
		issue_op(OP_READ, 16'hffff, 16'h0000);
		issue_op(OP_WRITE, 16'h0000, 16'h0100);
		issue_op(OP_READ, 16'h0000, 16'hffff);
		issue_op(OP_WRITE, 16'h0100, {8'h00, OPC_LDI});
		issue_op(OP_WRITE, 16'h0101, 16'h0010);
		issue_op(OP_WRITE, 16'h0102, {8'h00, OPC_SHL});
		issue_op(OP_WRITE, 16'h0103, {8'h00, OPC_HALT});
		issue_op(OP_RESTART, 16'h0000, 16'h0000);
		repeat (4) issue_op(OP_STEP, 16'h0000, 16'h0000);
		issue_op(OP_READ, 16'h0101, 16'h0000);
		issue_op(OP_WRITE, 16'h0100, {8'h00, OPC_SLEEP});
		issue_op(OP_RESTART, 16'h0000, 16'h0000);
		repeat (3) issue_op(OP_STEP, 16'h0000, 16'h0000);
		issue_op(OP_RESTART, 16'h0000, 16'h0000);
		wait_drained();

		// Random phases, each under its own settings. Most beats are steps so
		// that programs run deep; restarts wake cores and clear a halt.
		for (int p = 0; p < 6; p++) begin
			write_setting(CFG_ACTIVE, {13'd0, phase_cores[p]});
			write_setting(CFG_RVEC, phase_rvec[p]);
			write_setting(CFG_IVEC, phase_ivec[p]);
			issue_op(OP_RESTART, 16'h0000, 16'h0000);
			for (k = 0; k < 270; k++) begin
				sel = $urandom_range(0, 99);
				if (sel < 78) begin
					issue_op(OP_STEP, 16'($urandom), 16'($urandom));
				end else if (sel < 88) begin
					issue_op(OP_WRITE, 16'($urandom), random_instruction());
				end else if (sel < 96) begin
					issue_op(OP_READ, 16'($urandom), 16'($urandom));
				end else begin
					issue_op(OP_RESTART, 16'($urandom), 16'($urandom));
				end
			end
			// In the second phase the receiver holds off while beats keep coming.
			if (p == 1) begin
				hold_go <= 1'b1;
			end
			// The sender then pauses until every result is back.
			wait_drained();
		end

		if (mismatches == 0) begin
			$display("sixteen_bit_multicore_cpu_step test passed");
		end else begin
			$display("sixteen_bit_multicore_cpu_step test failed");
		end
		$finish;
	end

endmodule
